[src/assert_macros.svh]
// assertion helper macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[src/ppwc_pkg.sv]
// shared types, constants and commands of the planar pixel write combiner
`default_nettype none
package ppwc_pkg;
  localparam int MaxPlanes   = 8;
  localparam int PlaneWords  = 4096;
  localparam int CachePixels = 32;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_GET   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [1:0] REG_BPR    = 2'd0;
  localparam logic [1:0] REG_PCOUNT = 2'd1;
  localparam logic [1:0] REG_ONES   = 2'd2;
  localparam logic [1:0] REG_ABSENT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FLUSH,
    ST_LOOKUP,
    ST_OUT
  } ppwc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture input transaction
    logic calc;        // register address and pixel index
    logic flush_step;  // flush read/merge/write step of the current plane
    logic flush_end;   // clear the write mask; invalidate the tag unless a new base is set
    logic set_base;    // take the new word base
    logic look_step;   // lookup read step of the current plane
    logic look_end;    // finish the result
    logic clr_plane;   // reset the plane counter
  } ppwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       dirty;
    logic       plane_last;
    logic       masked;
    logic       busy;        // frame store clearing pass running
  } ppwc_stat_t;
endpackage
`default_nettype wire

[src/ppwc_ctrl.sv]
// controller state machine sequencing flush and plane lookups
`default_nettype none
module ppwc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire ppwc_pkg::ppwc_stat_t stat,
  output ppwc_pkg::ppwc_cmd_t       cmd
);
  ppwc_pkg::ppwc_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppwc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ppwc_pkg::ST_IDLE: begin
        // no transaction taken while the frame store is being cleared
        in_tready = !stat.busy;
        if (in_tvalid && !stat.busy) begin
          cmd.load_in = 1'b1;
          state_nxt   = ppwc_pkg::ST_CALC;
        end
      end
      ppwc_pkg::ST_CALC: begin
        cmd.calc      = 1'b1;
        cmd.clr_plane = 1'b1;
        state_nxt     = ppwc_pkg::ST_FLUSH;
      end
      ppwc_pkg::ST_FLUSH: begin
        // flush needed on explicit flush or on a miss of put/get
        if (stat.func == ppwc_pkg::FUNC_FLUSH ||
            ((stat.func == ppwc_pkg::FUNC_PUT || stat.func == ppwc_pkg::FUNC_GET) &&
             !stat.hit)) begin
          if (stat.dirty) begin
            cmd.flush_step = 1'b1;
            if (stat.plane_last) begin
              cmd.flush_end = 1'b1;
              cmd.clr_plane = 1'b1;
              cmd.set_base  = 1'b1;
              state_nxt     = ppwc_pkg::ST_LOOKUP;
            end
          end else begin
            cmd.flush_end = 1'b1;
            cmd.clr_plane = 1'b1;
            cmd.set_base  = 1'b1;
            state_nxt     = ppwc_pkg::ST_LOOKUP;
          end
        end else begin
          state_nxt = ppwc_pkg::ST_LOOKUP;
        end
      end
      ppwc_pkg::ST_LOOKUP: begin
        if (stat.func == ppwc_pkg::FUNC_GET && !stat.masked) begin
          cmd.look_step = 1'b1;
          if (stat.plane_last) state_nxt = ppwc_pkg::ST_OUT;
        end else begin
          state_nxt = ppwc_pkg::ST_OUT;
        end
      end
      ppwc_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.look_end  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ppwc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppwc_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[src/ppwc_dpath.sv]
// datapath: address arithmetic, pixel cache, plane memory and merge logic
`default_nettype none
module ppwc_dpath #(
  parameter int MAX_PLANES  = ppwc_pkg::MaxPlanes,
  parameter int PLANE_WORDS = ppwc_pkg::PlaneWords
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [31:0]          in_tdata,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [8:0]           cfg_data,
  input  wire ppwc_pkg::ppwc_cmd_t  cmd,
  output ppwc_pkg::ppwc_stat_t      stat,
  output logic [7:0]                read_value
);
  localparam int WAW = $clog2(PLANE_WORDS);
  localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int MW  = $clog2(MAX_PLANES * PLANE_WORDS);

  // configuration registers
  logic [8:0] bpr_r;
  logic [3:0] pcount_r;
  logic [7:0] ones_r, absent_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_r    <= 9'd40;
      pcount_r <= 4'd5;
      ones_r   <= '0;
      absent_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppwc_pkg::REG_BPR:    bpr_r    <= cfg_data;
        ppwc_pkg::REG_PCOUNT: pcount_r <= cfg_data[3:0];
        ppwc_pkg::REG_ONES:   ones_r   <= cfg_data[7:0];
        ppwc_pkg::REG_ABSENT: absent_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // captured input transaction
  logic [1:0]  func_r;
  logic [10:0] x_r;
  logic [9:0]  y_r;
  logic [7:0]  val_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_tdata[1:0];
      x_r    <= in_tdata[12:2];
      y_r    <= in_tdata[22:13];
      val_r  <= in_tdata[30:23];
    end
  end

  // word base and pixel index, one multiply registered
  logic [19:0] off_r;
  logic [19:0] off_c;
  assign off_c = 20'(x_r[10:3]) + 20'(y_r) * 20'(bpr_r);
  logic [4:0] k_r;
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      off_r <= off_c;
      k_r   <= {off_c[1:0], x_r[2:0]};
    end
  end
  logic [19:0] base_w;
  assign base_w = {off_r[19:2], 2'b00};

  // cache tag, mask and pixels
  logic        cvalid_r;
  logic [19:0] cbase_r;
  logic [31:0] mask_r;
  logic [7:0]  cache_r [ppwc_pkg::CachePixels];
  logic [7:0]  lookup_r;

  // plane counter and effective depth
  logic [PW:0] plane_r;
  logic [PW:0] depth;
  assign depth = (pcount_r > 4'(MAX_PLANES)) ? (PW+1)'(MAX_PLANES) : (PW+1)'(pcount_r);
  logic [PW-1:0] pidx;
  assign pidx = plane_r[PW-1:0];
  logic [2:0] p3;
  assign p3 = 3'(pidx);

  // plane memory, one read and one write port, registered read
  logic [31:0] mem_r [MAX_PLANES * PLANE_WORDS];
  logic [MW-1:0] raddr, waddr;
  logic [WAW-1:0] woff_rd;
  assign woff_rd = cmd.flush_step ? cbase_r[WAW+1:2] : base_w[WAW+1:2];
  assign raddr   = MW'({pidx, woff_rd});
  // clearing pass after reset zeroes every plane word
  logic        clr_busy_r;
  logic [MW-1:0] clr_addr_r;
  logic [31:0] rdata_r;
  logic        phase_r;  // use phase of each plane step
  logic [31:0] merged;
  logic        real_p;
  assign real_p = !ones_r[p3] && !absent_r[p3];
  assign waddr = clr_busy_r ? clr_addr_r : raddr;

  always_comb begin
    merged = rdata_r;
    for (int k = 0; k < 32; k++) begin
      if (mask_r[k]) merged[31-k] = cache_r[k][p3];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
    if (clr_busy_r) mem_r[waddr] <= '0;
    else if (cmd.flush_step && phase_r && real_p && plane_r < depth) mem_r[waddr] <= merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == MW'(MAX_PLANES * PLANE_WORDS - 1)) clr_busy_r <= 1'b0;
    end
  end

  // plane step control: each plane takes a read phase then a use phase
  logic step;
  assign step = cmd.flush_step || cmd.look_step;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      plane_r <= '0;
    end else if (cmd.clr_plane && !step) begin
      phase_r <= 1'b0;
      plane_r <= '0;
    end else if (step) begin
      phase_r <= !phase_r;
      if (phase_r) plane_r <= cmd.clr_plane ? '0 : plane_r + 1'b1;
    end
  end

  // plane value seen by a lookup
  logic [31:0] pword;
  assign pword = ones_r[p3] ? 32'hffffffff : (absent_r[p3] ? 32'h0 : rdata_r);

  // tag and write mask; a new base for a put or get overrides the invalidation of the flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= 1'b0;
      mask_r   <= '0;
      cbase_r  <= '0;
    end else begin
      if (cmd.set_base && func_r != ppwc_pkg::FUNC_FLUSH) begin
        cvalid_r <= 1'b1;
        cbase_r  <= base_w;
      end else if (cmd.flush_end) begin
        cvalid_r <= 1'b0;
      end
      if (cmd.flush_end) mask_r <= '0;
      else if (cmd.look_end && func_r == ppwc_pkg::FUNC_PUT) mask_r[k_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_plane && !cmd.flush_step) lookup_r <= '0;
    else if (cmd.look_step && phase_r && plane_r < depth)
      lookup_r[p3] <= pword[5'd31 - k_r];
    if (cmd.look_end && func_r == ppwc_pkg::FUNC_PUT) cache_r[k_r] <= val_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.look_end) begin
      if (func_r == ppwc_pkg::FUNC_GET)
        read_value <= mask_r[k_r] ? cache_r[k_r] : lookup_r;
      else
        read_value <= '0;
    end
  end

  assign stat.func       = func_r;
  assign stat.hit        = cvalid_r && (cbase_r == base_w);
  assign stat.dirty      = cvalid_r && (mask_r != '0);
  assign stat.plane_last = phase_r && ((plane_r + 1'b1) >= depth || plane_r == (PW+1)'(MAX_PLANES-1));
  assign stat.masked     = mask_r[k_r] || depth == '0;
  assign stat.busy       = clr_busy_r;
endmodule
`default_nettype wire

[src/planar_pixel_write_combiner_unit.sv]
// Top level: a transaction is taken only in the idle state; it passes through the calc, flush,
// lookup and output states, and the result is registered; a new transaction waits for idle.
// A flush or a miss with written pixels runs a read and a merge-write phase per plane below
// plane_count and MAX_PLANES (min 1 step); a get of an unwritten pixel (plane_count > 0) reads
// each such plane. A result not taken holds the block in its output state; after reset in_tready
// stays low until the frame store clearing pass is done, and registers reload their defaults.
`default_nettype none
module planar_pixel_write_combiner_unit #(
  parameter int MAX_PLANES  = ppwc_pkg::MaxPlanes,
  parameter int PLANE_WORDS = ppwc_pkg::PlaneWords
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // func[1:0] pixel_x[12:2] pixel_y[22:13] pixel_value[30:23]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // read_value[7:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  ppwc_pkg::ppwc_cmd_t  cmd;
  ppwc_pkg::ppwc_stat_t stat;
  logic ready_c;

  assign cfg_ready = 1'b1;

  ppwc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready(ready_c), .out_tvalid, .out_tready,
    .stat, .cmd
  );

  ppwc_dpath #(.MAX_PLANES(MAX_PLANES), .PLANE_WORDS(PLANE_WORDS)) u_dpath (
    .clk, .rst_n, .in_tdata, .cfg_valid, .cfg_index, .cfg_data,
    .cmd, .stat, .read_value(out_tdata)
  );

  assign in_tready = ready_c;
endmodule
`default_nettype wire

[src/ppwc_checker.sv]
// port checker bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ppwc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [7:0] out_tdata
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `CHK_NEXT(a_data_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `CHK_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `CHK_IMPL(a_hs_known, clk, rst_n, 1'b1, !$isunknown({in_tready, out_tvalid}))
endmodule
bind planar_pixel_write_combiner_unit ppwc_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
